// ----- design/wlc_pkg.sv -----
// Shared types and constants of the triangle waterline clipper.
// No dependencies; every other design file imports it.
package wlc_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned AREA_W  = 48;
  localparam int unsigned QDEPTH  = 2;

  // One vertex, index 0 = x, 1 = y, 2 = z.
  typedef logic [2:0][COORD_W-1:0] vtx_t;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by_coord;
    logic signed [31:0] bz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] dist_a;
    logic signed [31:0] dist_b;
    logic signed [31:0] dist_c;
  } wlc_in_t;

  typedef struct packed {
    logic signed [31:0] p0x;
    logic signed [31:0] p0y;
    logic signed [31:0] p0z;
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] p1z;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] p2z;
    logic               underwater;
    logic               last_piece;
    logic [47:0]        submerged_area;
  } wlc_out_t;

  typedef enum logic [1:0] {
    KIND_UNDER,
    KIND_ABOVE,
    KIND_ONE_UP,
    KIND_TWO_UP
  } job_kind_e;

  // s0..s2 are the vertices in role order; cut0 runs s0->s1, cut1 runs
  // s2->s1 for one vertex above and s0->s2 for two above.
  typedef struct packed {
    job_kind_e          kind;
    vtx_t               s0;
    vtx_t               s1;
    vtx_t               s2;
    logic [COORD_W-1:0] num0;
    logic [COORD_W-1:0] den0;
    logic [COORD_W-1:0] num1;
    logic [COORD_W-1:0] den1;
  } wlc_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_MUL,
    CT_DIV,
    CT_DONE
  } ct_state_e;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_MUL,
    AR_HALF,
    AR_SQ,
    AR_ADD,
    AR_SUM,
    AR_ROOT,
    AR_DONE
  } ar_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_CUT,
    BK_A1GO,
    BK_A1WAIT,
    BK_A2GO,
    BK_A2WAIT,
    BK_EMIT
  } bk_state_e;

endpackage

// ----- design/wlc_front.sv -----
// Front end: accepts a triangle, classifies it against the waterline and
// orders its vertices into roles. Depends on wlc_pkg.
module wlc_front import wlc_pkg::*; (
  input  logic     start_i,
  input  logic     full_i,
  input  wlc_in_t  item_i,
  output logic     push_o,
  output wlc_job_t job_o
);

  vtx_t               v [3];
  logic signed [31:0] d [3];
  logic [2:0]         up;
  logic [1:0]         i0, i1, i2, p1i, q1i;
  logic [32:0]        nw0, dw0, nw1, dw1;

  assign push_o = start_i & ~full_i;

  always_comb begin
    v[0] = {item_i.az, item_i.ay, item_i.ax};
    v[1] = {item_i.bz, item_i.by_coord, item_i.bx};
    v[2] = {item_i.cz, item_i.cy, item_i.cx};
    d[0] = item_i.dist_a;
    d[1] = item_i.dist_b;
    d[2] = item_i.dist_c;
    for (int i = 0; i < 3; i++) begin
      up[i] = d[i] > 32'sd0;
    end
  end

  // Roles: one above -> (before H, H, after H); two above -> (L, after L, before L).
  always_comb begin
    unique case (up)
      3'b000: begin job_o.kind = KIND_UNDER;  i0 = 2'd0; i1 = 2'd1; i2 = 2'd2; end
      3'b111: begin job_o.kind = KIND_ABOVE;  i0 = 2'd0; i1 = 2'd1; i2 = 2'd2; end
      3'b001: begin job_o.kind = KIND_ONE_UP; i0 = 2'd2; i1 = 2'd0; i2 = 2'd1; end
      3'b010: begin job_o.kind = KIND_ONE_UP; i0 = 2'd0; i1 = 2'd1; i2 = 2'd2; end
      3'b100: begin job_o.kind = KIND_ONE_UP; i0 = 2'd1; i1 = 2'd2; i2 = 2'd0; end
      3'b110: begin job_o.kind = KIND_TWO_UP; i0 = 2'd0; i1 = 2'd1; i2 = 2'd2; end
      3'b101: begin job_o.kind = KIND_TWO_UP; i0 = 2'd1; i1 = 2'd2; i2 = 2'd0; end
      3'b011: begin job_o.kind = KIND_TWO_UP; i0 = 2'd2; i1 = 2'd0; i2 = 2'd1; end
    endcase
  end

  always_comb begin
    if (job_o.kind == KIND_ONE_UP) begin
      p1i = i2;
      q1i = i1;
    end else begin
      p1i = i0;
      q1i = i2;
    end
    nw0 = 33'd0 - {d[i0][31], d[i0]};
    dw0 = {d[i1][31], d[i1]} - {d[i0][31], d[i0]};
    nw1 = 33'd0 - {d[p1i][31], d[p1i]};
    dw1 = {d[q1i][31], d[q1i]} - {d[p1i][31], d[p1i]};
    job_o.s0   = v[i0];
    job_o.s1   = v[i1];
    job_o.s2   = v[i2];
    job_o.num0 = nw0[COORD_W-1:0];
    job_o.den0 = dw0[COORD_W-1:0];
    job_o.num1 = nw1[COORD_W-1:0];
    job_o.den1 = dw1[COORD_W-1:0];
  end

endmodule

// ----- design/wlc_fifo.sv -----
// Short job queue between the front end and the back end.
// Depends on wlc_pkg.
module wlc_fifo import wlc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  wlc_job_t  job_i,
  input  logic      pop_i,
  output wlc_job_t  head_o,
  output q_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  wlc_job_t         mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.full  = cnt_q == CNT_W'(QDEPTH);
  assign status_o.empty = cnt_q == '0;

endmodule

// ----- design/wlc_cut.sv -----
// Edge cut unit: P + trunc((Q - P) * num / den) on three axes, one
// quotient bit per cycle per axis. Depends on wlc_pkg.
module wlc_cut import wlc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  vtx_t               p_i,
  input  vtx_t               q_i,
  input  logic [COORD_W-1:0] num_i,
  input  logic [COORD_W-1:0] den_i,
  output logic               done_o,
  output vtx_t               cut_o
);

  localparam int unsigned CNT_W = $clog2(COORD_W);

  ct_state_e          state_q, state_d;
  logic [CNT_W-1:0]   cnt_q;
  vtx_t               p_q;
  logic [2:0]         neg_q;
  logic [2:0][31:0]   mag_q, rem_q, quo_q;
  logic [31:0]        num_q, den_q;
  logic [2:0][32:0]   dw, magw, tr;
  logic [2:0][63:0]   prod;
  logic [2:0]         ge;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CT_IDLE: if (start_i) state_d = CT_MUL;
      CT_MUL:  state_d = CT_DIV;
      CT_DIV:  if (cnt_q == CNT_W'(COORD_W - 1)) state_d = CT_DONE;
      CT_DONE: state_d = CT_IDLE;
    endcase
  end

  always_comb begin
    done_o = state_q == CT_DONE;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dw[k]   = {q_i[k][31], q_i[k]} - {p_i[k][31], p_i[k]};
      magw[k] = dw[k][32] ? 33'd0 - dw[k] : dw[k];
      prod[k] = 64'(mag_q[k]) * 64'(num_q);
      tr[k]   = {rem_q[k], quo_q[k][31]};
      ge[k]   = tr[k] >= {1'b0, den_q};
      cut_o[k] = neg_q[k] ? p_q[k] - quo_q[k] : p_q[k] + quo_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CT_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == CT_MUL) cnt_q <= '0;
      else if (state_q == CT_DIV) cnt_q <= cnt_q + 1'b1;
    end
  end

  // Quotient bits shift into the low word as the dividend bits leave it.
  always_ff @(posedge clk_i) begin
    if (state_q == CT_IDLE && start_i) begin
      p_q   <= p_i;
      num_q <= num_i;
      den_q <= den_i;
      for (int k = 0; k < 3; k++) begin
        neg_q[k] <= dw[k][32];
        mag_q[k] <= magw[k][31:0];
      end
    end
    if (state_q == CT_MUL) begin
      for (int k = 0; k < 3; k++) begin
        rem_q[k] <= prod[k][63:32];
        quo_q[k] <= prod[k][31:0];
      end
    end
    if (state_q == CT_DIV) begin
      for (int k = 0; k < 3; k++) begin
        rem_q[k] <= ge[k] ? 32'(tr[k] - {1'b0, den_q}) : tr[k][31:0];
        quo_q[k] <= {quo_q[k][30:0], ge[k]};
      end
    end
  end

endmodule

// ----- design/wlc_area.sv -----
// Triangle area unit: cross product, halved components, sum of squares
// and a two-bit-per-step square root. Depends on wlc_pkg.
module wlc_area import wlc_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  vtx_t              p0_i,
  input  vtx_t              p1_i,
  input  vtx_t              p2_i,
  output logic              done_o,
  output logic [AREA_W-1:0] area_o
);

  localparam int unsigned ROOT_STEPS = 64;
  localparam int unsigned CNT_W      = $clog2(ROOT_STEPS);

  ar_state_e          state_q, state_d;
  logic [CNT_W-1:0]   cnt_q;
  logic signed [32:0] u_q [3];
  logic signed [32:0] v_q [3];
  logic signed [65:0] pa_q [3];
  logic signed [65:0] pb_q [3];
  logic [63:0]        half_q [3];
  logic [63:0]        hh_q [3];
  logic [63:0]        hl_q [3];
  logic [63:0]        ll_q [3];
  logic [127:0]       sq_q [3];
  logic [127:0]       rad_q;
  logic [65:0]        rem_q;
  logic [63:0]        root_q;
  logic               sat_q;
  logic [32:0]        du [3];
  logic [32:0]        dv [3];
  logic signed [66:0] cw [3];
  logic [66:0]        cm [3];
  logic [129:0]       tot;
  logic [66:0]        rem_n, trial;
  logic               rge;
  logic [63:0]        shr;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      AR_IDLE: if (start_i) state_d = AR_MUL;
      AR_MUL:  state_d = AR_HALF;
      AR_HALF: state_d = AR_SQ;
      AR_SQ:   state_d = AR_ADD;
      AR_ADD:  state_d = AR_SUM;
      AR_SUM:  state_d = AR_ROOT;
      AR_ROOT: if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_d = AR_DONE;
      AR_DONE: state_d = AR_IDLE;
    endcase
  end

  always_comb begin
    done_o = state_q == AR_DONE;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      du[i] = {p1_i[i][31], p1_i[i]} - {p0_i[i][31], p0_i[i]};
      dv[i] = {p2_i[i][31], p2_i[i]} - {p0_i[i][31], p0_i[i]};
      cw[i] = 67'(pa_q[i]) - 67'(pb_q[i]);
      cm[i] = cw[i][66] ? 67'(-cw[i]) : 67'(cw[i]);
    end
    tot   = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
    rem_n = {rem_q[64:0], rad_q[127:126]};
    trial = {1'b0, root_q, 2'b01};
    rge   = rem_n >= trial;
    shr   = root_q >> COORD_FRAC_BITS;
    area_o = (sat_q || (|shr[63:AREA_W])) ? '1 : shr[AREA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == AR_SUM) cnt_q <= '0;
      else if (state_q == AR_ROOT) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == AR_IDLE && start_i) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= $signed(du[i]);
        v_q[i] <= $signed(dv[i]);
      end
    end
    if (state_q == AR_MUL) begin
      pa_q[0] <= 66'(u_q[1]) * 66'(v_q[2]);
      pb_q[0] <= 66'(u_q[2]) * 66'(v_q[1]);
      pa_q[1] <= 66'(u_q[2]) * 66'(v_q[0]);
      pb_q[1] <= 66'(u_q[0]) * 66'(v_q[2]);
      pa_q[2] <= 66'(u_q[0]) * 66'(v_q[1]);
      pb_q[2] <= 66'(u_q[1]) * 66'(v_q[0]);
    end
    if (state_q == AR_HALF) begin
      for (int i = 0; i < 3; i++) half_q[i] <= cm[i][64:1];
    end
    if (state_q == AR_SQ) begin
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= 64'(half_q[i][63:32]) * 64'(half_q[i][63:32]);
        hl_q[i] <= 64'(half_q[i][63:32]) * 64'(half_q[i][31:0]);
        ll_q[i] <= 64'(half_q[i][31:0]) * 64'(half_q[i][31:0]);
      end
    end
    if (state_q == AR_ADD) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= {hh_q[i], 64'd0} + {31'd0, hl_q[i], 33'd0} + {64'd0, ll_q[i]};
      end
    end
    if (state_q == AR_SUM) begin
      sat_q  <= |tot[129:128];
      rad_q  <= tot[127:0];
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == AR_ROOT) begin
      rem_q  <= rge ? 66'(rem_n - trial) : rem_n[65:0];
      root_q <= {root_q[62:0], rge};
      rad_q  <= {rad_q[125:0], 2'b00};
    end
  end

endmodule

// ----- design/wlc_back.sv -----
// Back end: pops a job, runs the two cuts and up to two areas, then
// issues the pieces. Depends on wlc_pkg, wlc_cut and wlc_area.
module wlc_back import wlc_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t status_i,
  input  wlc_job_t  head_i,
  output logic      pop_o,
  output logic      strobe_o,
  output wlc_out_t  res_o
);

  bk_state_e         state_q, state_d;
  wlc_job_t          job_q;
  vtx_t              c0_q, c1_q;
  logic [AREA_W-1:0] area1_q, area_q;
  logic [1:0]        pc_q;
  logic              strobe_q;
  wlc_out_t          res_q;

  logic              split, one_up, last, cut_go, area_go, emit;
  logic              cut0_done, cut1_done, area_done;
  vtx_t              cut0, cut1, c1p, c1q, ap1, ap2, pv0, pv1, pv2;
  logic              und;
  logic [AREA_W-1:0] area_r;
  logic [AREA_W:0]   asum;

  assign one_up = job_q.kind == KIND_ONE_UP;
  assign split  = one_up || job_q.kind == KIND_TWO_UP;
  assign last   = !split || pc_q == 2'd2;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!status_i.empty) state_d = BK_LOAD;
      BK_LOAD: begin
        unique case (job_q.kind)
          KIND_UNDER:  state_d = BK_A1GO;
          KIND_ABOVE:  state_d = BK_EMIT;
          KIND_ONE_UP: state_d = BK_CUT;
          KIND_TWO_UP: state_d = BK_CUT;
        endcase
      end
      BK_CUT:    if (cut0_done && cut1_done) state_d = BK_A1GO;
      BK_A1GO:   state_d = BK_A1WAIT;
      BK_A1WAIT: if (area_done) state_d = one_up ? BK_A2GO : BK_EMIT;
      BK_A2GO:   state_d = BK_A2WAIT;
      BK_A2WAIT: if (area_done) state_d = BK_EMIT;
      BK_EMIT:   if (last) state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o   = state_q == BK_IDLE && !status_i.empty;
    cut_go  = state_q == BK_LOAD && split;
    area_go = state_q == BK_A1GO || state_q == BK_A2GO;
    emit    = state_q == BK_EMIT;
  end

  always_comb begin
    c1p = one_up ? job_q.s2 : job_q.s0;
    c1q = one_up ? job_q.s1 : job_q.s2;
    if (state_q == BK_A2GO) begin
      ap1 = c1_q;
      ap2 = job_q.s2;
    end else if (split) begin
      ap1 = c0_q;
      ap2 = c1_q;
    end else begin
      ap1 = job_q.s1;
      ap2 = job_q.s2;
    end
  end

  wlc_cut u_cut0 (
    .clk_i, .rst_ni, .start_i(cut_go), .p_i(job_q.s0), .q_i(job_q.s1),
    .num_i(job_q.num0), .den_i(job_q.den0), .done_o(cut0_done), .cut_o(cut0)
  );

  wlc_cut u_cut1 (
    .clk_i, .rst_ni, .start_i(cut_go), .p_i(c1p), .q_i(c1q),
    .num_i(job_q.num1), .den_i(job_q.den1), .done_o(cut1_done), .cut_o(cut1)
  );

  wlc_area #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_area (
    .clk_i, .rst_ni, .start_i(area_go), .p0_i(job_q.s0), .p1_i(ap1), .p2_i(ap2),
    .done_o(area_done), .area_o(area_r)
  );

  always_comb begin
    pv0 = job_q.s0;
    pv1 = job_q.s1;
    pv2 = job_q.s2;
    und = 1'b0;
    unique case (job_q.kind)
      KIND_UNDER: und = 1'b1;
      KIND_ABOVE: und = 1'b0;
      KIND_ONE_UP: begin
        unique case (pc_q)
          2'd0:    begin pv0 = job_q.s0; pv1 = c0_q; pv2 = c1_q; und = 1'b1; end
          2'd1:    begin pv0 = job_q.s0; pv1 = c1_q; pv2 = job_q.s2; und = 1'b1; end
          default: begin pv0 = c0_q; pv1 = job_q.s1; pv2 = c1_q; und = 1'b0; end
        endcase
      end
      KIND_TWO_UP: begin
        unique case (pc_q)
          2'd0:    begin pv0 = job_q.s0; pv1 = c0_q; pv2 = c1_q; und = 1'b1; end
          2'd1:    begin pv0 = c0_q; pv1 = job_q.s1; pv2 = c1_q; und = 1'b0; end
          default: begin pv0 = c1_q; pv1 = job_q.s1; pv2 = job_q.s2; und = 1'b0; end
        endcase
      end
    endcase
    asum = {1'b0, area1_q} + {1'b0, area_r};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      strobe_q <= 1'b0;
      pc_q     <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= emit;
      if (state_q == BK_LOAD) pc_q <= '0;
      else if (emit) pc_q <= pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= head_i;
    if (state_q == BK_LOAD) area_q <= '0;
    if (state_q == BK_CUT && cut0_done) begin
      c0_q <= cut0;
      c1_q <= cut1;
    end
    if (state_q == BK_A1WAIT && area_done) begin
      area1_q <= area_r;
      area_q  <= area_r;
    end
    // Sum of the two underwater pieces, held at the top of the range.
    if (state_q == BK_A2WAIT && area_done) begin
      area_q <= asum[AREA_W] ? '1 : asum[AREA_W-1:0];
    end
    if (emit) begin
      res_q.p0x            <= pv0[0];
      res_q.p0y            <= pv0[1];
      res_q.p0z            <= pv0[2];
      res_q.p1x            <= pv1[0];
      res_q.p1y            <= pv1[1];
      res_q.p1z            <= pv1[2];
      res_q.p2x            <= pv2[0];
      res_q.p2y            <= pv2[1];
      res_q.p2z            <= pv2[2];
      res_q.underwater     <= und;
      res_q.last_piece     <= last;
      res_q.submerged_area <= area_q;
    end
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

// ----- design/triangle_waterline_clipper.sv -----
// Top level of the triangle waterline clipper.
// Depends on wlc_pkg, wlc_front, wlc_fifo and wlc_back.
//
// A triangle is taken when start is high and busy is low; a two-entry job
// queue lets start be taken while an earlier triangle is still being
// worked, and busy rises only when that queue is full. Results leave one
// piece per cycle on res_o, marked by res_strobe_o, and cannot be held
// off: the pieces of one triangle come in back-to-back cycles, the last
// one flagged by last_piece, all carrying the same submerged area. The
// back end works one triangle at a time; the 64-step square root in the
// area unit, run once per underwater area, sets most of the time that a
// triangle takes there, and the 32-step edge division adds to it for
// triangles that cross the waterline.
module triangle_waterline_clipper import wlc_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  wlc_in_t  item_i,
  output logic     res_strobe_o,
  output wlc_out_t res_o
);

  logic      push, pop;
  wlc_job_t  job, head;
  q_status_t qstat;

  assign busy = qstat.full;

  wlc_front u_front (
    .start_i(start), .full_i(qstat.full), .item_i, .push_o(push), .job_o(job)
  );

  wlc_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .job_i(job), .pop_i(pop),
    .head_o(head), .status_o(qstat)
  );

  wlc_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .status_i(qstat), .head_i(head), .pop_o(pop),
    .strobe_o(res_strobe_o), .res_o
  );

endmodule

// ----- design/wlc_checker.sv -----
// Port-level checks on the result stream of the clipper, bound to the
// top level. Depends on wlc_pkg.
module wlc_checker import wlc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     res_strobe_i,
  input wlc_out_t res_i
);

  // Pieces of one triangle leave in consecutive cycles.
  a_pieces_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i && !res_i.last_piece |=> res_strobe_i)
    else $error("piece run broken before last_piece");

  a_area_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i && !res_i.last_piece |=> $stable(res_i.submerged_area))
    else $error("submerged area changed within one triangle");

  a_max_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i && $past(res_strobe_i) && $past(res_strobe_i, 2) |-> res_i.last_piece)
    else $error("more than three pieces for one triangle");

  // A lone above-water piece is a dry triangle.
  a_dry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i && !$past(res_strobe_i) && res_i.last_piece && !res_i.underwater
    |-> res_i.submerged_area == '0)
    else $error("dry triangle reports a submerged area");

endmodule

bind triangle_waterline_clipper wlc_checker u_wlc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .res_strobe_i(res_strobe_o),
  .res_i(res_o)
);
